// File: rtl/lensd_pkg.sv
// ----------------------------------------------------------------------------
// lensd_pkg
// Shared types, constants and rounding helper for the lens distortion map.
// ----------------------------------------------------------------------------
package lensd_pkg;

    localparam int FRAC   = 20;               // fraction bits of normalized values
    localparam int XN_W   = 23;               // normalized coordinate width
    localparam int REM_W  = 39;               // divider remainder width
    localparam int XD_W   = 39;               // saturated distorted coordinate width
    localparam int OUT_W  = 18;

    localparam logic signed [XN_W-1:0]  XN_MAX  = 23'sh3FFFFF;
    localparam logic signed [XN_W-1:0]  XN_MIN  = -23'sh400000;
    localparam logic signed [XD_W-1:0]  XD_MAX  = 39'sh3FFFFFFFFF;
    localparam logic signed [XD_W-1:0]  XD_MIN  = -39'sh4000000000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;
    localparam logic signed [36:0]      ONE_Q20 = 37'sd1048576;

    localparam logic [15:0] FOCAL_RST = 16'd16384;

    typedef enum logic [2:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_PRINCIPAL = 3'd2,
        CFG_K1        = 3'd3,
        CFG_K2        = 3'd4,
        CFG_K3        = 3'd5,
        CFG_P1        = 3'd6,
        CFG_P2        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [15:0] fx;   // zero focal already replaced by one
        logic        [15:0] fy;
        logic        [15:0] cx;
        logic        [15:0] cy;
        logic signed [23:0] k1;
        logic signed [23:0] k2;
        logic signed [23:0] k3;
        logic signed [23:0] p1;
        logic signed [23:0] p2;
    } t_cfg;

    // round half up and drop the q20 fraction
    function automatic logic signed [63:0] rnd_q20(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v + 64'sd524288;
        return s >>> FRAC;
    endfunction

endpackage

// File: rtl/lens_distortion_point_map_core.sv
// ----------------------------------------------------------------------------
// lens_distortion_point_map_core
// Brown-Conrady forward lens distortion of one pixel coordinate per clock.
// ----------------------------------------------------------------------------
// pipeline: 25 normalize stages, 14 distortion stages, one output register
// throughput: one transaction per cycle; the whole pipeline holds only when
//   the output skid register is occupied
// reset: synchronous, active low; clears valid bits, loads default registers
// ----------------------------------------------------------------------------
module lens_distortion_point_map_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_pixel_x,
    input  logic [15:0]         i_pixel_y,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [17:0]  o_mapped_x,
    output logic signed [17:0]  o_mapped_y,
    output logic                o_clipped,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    logic [15:0]        r_focal_x, r_focal_y;
    logic [31:0]        r_principal;
    logic signed [23:0] r_k1, r_k2, r_k3, r_p1, r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= lensd_pkg::FOCAL_RST;
            r_focal_y   <= lensd_pkg::FOCAL_RST;
            r_principal <= '0;
            r_k1        <= '0;
            r_k2        <= '0;
            r_k3        <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
        end else if (i_cfg_we) begin
            unique case (lensd_pkg::t_cfg_idx'(i_cfg_idx))
                lensd_pkg::CFG_FOCAL_X:   r_focal_x   <= i_cfg_data[15:0];
                lensd_pkg::CFG_FOCAL_Y:   r_focal_y   <= i_cfg_data[15:0];
                lensd_pkg::CFG_PRINCIPAL: r_principal <= i_cfg_data;
                lensd_pkg::CFG_K1:        r_k1        <= $signed(i_cfg_data[23:0]);
                lensd_pkg::CFG_K2:        r_k2        <= $signed(i_cfg_data[23:0]);
                lensd_pkg::CFG_K3:        r_k3        <= $signed(i_cfg_data[23:0]);
                lensd_pkg::CFG_P1:        r_p1        <= $signed(i_cfg_data[23:0]);
                lensd_pkg::CFG_P2:        r_p2        <= $signed(i_cfg_data[23:0]);
            endcase
        end
    end

    lensd_pkg::t_cfg cfg;

    always_comb begin
        cfg.fx = (r_focal_x == 16'h0) ? 16'h1 : r_focal_x;
        cfg.fy = (r_focal_y == 16'h0) ? 16'h1 : r_focal_y;
        cfg.cx = r_principal[15:0];
        cfg.cy = r_principal[31:16];
        cfg.k1 = r_k1;
        cfg.k2 = r_k2;
        cfg.k3 = r_k3;
        cfg.p1 = r_p1;
        cfg.p2 = r_p2;
    end

    logic               en;
    logic               nrm_v;
    logic signed [22:0] nrm_xn, nrm_yn;
    logic               nrm_clip;
    logic               dst_v;
    logic signed [17:0] dst_mx, dst_my;
    logic               dst_clip;

    logic               r_ov, r_sv;
    logic signed [17:0] r_omx, r_omy, r_smx, r_smy;
    logic               r_oclip, r_sclip;
    logic               pop, push;

    // pipeline moves whenever the skid slot is free
    assign en      = ~r_sv;
    assign o_ready = en;

    lensd_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (cfg),
        .o_valid   (nrm_v),
        .o_xn      (nrm_xn),
        .o_yn      (nrm_yn),
        .o_clip    (nrm_clip)
    );

    lensd_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (nrm_v),
        .i_xn       (nrm_xn),
        .i_yn       (nrm_yn),
        .i_clip     (nrm_clip),
        .i_cfg      (cfg),
        .o_valid    (dst_v),
        .o_mapped_x (dst_mx),
        .o_mapped_y (dst_my),
        .o_clipped  (dst_clip)
    );

    assign pop  = r_ov & i_ready;
    assign push = en & dst_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_ov && !pop) begin
                r_sv <= r_sv | push;
            end else if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && !pop) begin
            if (push) begin
                r_smx   <= dst_mx;
                r_smy   <= dst_my;
                r_sclip <= dst_clip;
            end
        end else if (r_sv) begin
            r_omx   <= r_smx;
            r_omy   <= r_smy;
            r_oclip <= r_sclip;
        end else if (push) begin
            r_omx   <= dst_mx;
            r_omy   <= dst_my;
            r_oclip <= dst_clip;
        end
    end

    assign o_valid    = r_ov;
    assign o_mapped_x = r_omx;
    assign o_mapped_y = r_omy;
    assign o_clipped  = r_oclip;

endmodule

// File: rtl/lensd_norm.sv
// ----------------------------------------------------------------------------
// lensd_norm
// Normalizes both coordinates: center offset, pipelined restoring divide by
// the focal length with round to nearest, clamp to the q20 range.
// ----------------------------------------------------------------------------
module lensd_norm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [15:0]                          i_pixel_x,
    input  logic [15:0]                          i_pixel_y,
    input  lensd_pkg::t_cfg                      i_cfg,
    output logic                                 o_valid,
    output logic signed [lensd_pkg::XN_W-1:0]    o_xn,
    output logic signed [lensd_pkg::XN_W-1:0]    o_yn,
    output logic                                 o_clip
);

    localparam int NB = lensd_pkg::XN_W;
    localparam int RW = lensd_pkg::REM_W;

    logic [15:0]    pix [2];
    logic [15:0]    cen [2];
    logic [15:0]    foc [2];

    logic [16:0]    n_d   [2];
    logic [15:0]    n_mag [2];
    logic [RW-1:0]  n_num [2];
    logic           n_ovf [2];

    logic [NB+1:0]  r_v;
    logic [RW-1:0]  r_rem [NB+1][2];
    logic [NB-1:0]  r_q   [NB+1][2];
    logic           r_neg [NB+1][2];
    logic           r_ovf [NB+1][2];

    logic signed [NB-1:0] r_xn;
    logic signed [NB-1:0] r_yn;
    logic                 r_clip;

    assign pix[0] = i_pixel_x;
    assign pix[1] = i_pixel_y;
    assign cen[0] = i_cfg.cx;
    assign cen[1] = i_cfg.cy;
    assign foc[0] = i_cfg.fx;
    assign foc[1] = i_cfg.fy;

    // entry: |d| * 2^20 + f/2, overflow when quotient would need more than NB bits
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_d[l]   = {1'b0, pix[l]} - {1'b0, cen[l]};
            n_mag[l] = n_d[l][16] ? 16'(-n_d[l]) : n_d[l][15:0];
            n_num[l] = {3'b000, n_mag[l], 20'h00000} + RW'(foc[l] >> 1);
            n_ovf[l] = n_num[l] >= {foc[l], 23'h000000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NB:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= n_num[l];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= n_d[l][16];
                r_ovf[0][l] <= n_ovf[l];
            end
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 1; s <= NB; s++) begin : g_div
        logic [RW-1:0] dvs [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                dvs[l] = RW'(foc[l]) << (NB - s);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_ovf[s][l] <= r_ovf[s-1][l];
                    if (r_rem[s-1][l] >= dvs[l]) begin
                        r_rem[s][l] <= r_rem[s-1][l] - dvs[l];
                        r_q[s][l]   <= r_q[s-1][l] | (NB'(1) << (NB - s));
                    end else begin
                        r_rem[s][l] <= r_rem[s-1][l];
                        r_q[s][l]   <= r_q[s-1][l];
                    end
                end
            end
        end
    end

    logic signed [NB-1:0] n_res [2];
    logic                 n_sat [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_neg[NB][l]) begin
                n_sat[l] = r_ovf[NB][l] || (r_q[NB][l] > NB'(23'h400000));
                n_res[l] = n_sat[l] ? lensd_pkg::XN_MIN : $signed(~r_q[NB][l] + NB'(1));
            end else begin
                n_sat[l] = r_ovf[NB][l] || (r_q[NB][l] > NB'(23'h3FFFFF));
                n_res[l] = n_sat[l] ? lensd_pkg::XN_MAX : $signed(r_q[NB][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn   <= n_res[0];
            r_yn   <= n_res[1];
            r_clip <= n_sat[0] | n_sat[1];
        end
    end

    assign o_valid = r_v[NB+1];
    assign o_xn    = r_xn;
    assign o_yn    = r_yn;
    assign o_clip  = r_clip;

endmodule

// File: rtl/lensd_dist.sv
// ----------------------------------------------------------------------------
// lensd_dist
// Radial and tangential distortion polynomial, back to pixel units,
// output saturation. Fourteen stages, at most one multiply level per stage.
// ----------------------------------------------------------------------------
module lensd_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [lensd_pkg::XN_W-1:0]    i_xn,
    input  logic signed [lensd_pkg::XN_W-1:0]    i_yn,
    input  logic                                 i_clip,
    input  lensd_pkg::t_cfg                      i_cfg,
    output logic                                 o_valid,
    output logic signed [lensd_pkg::OUT_W-1:0]   o_mapped_x,
    output logic signed [lensd_pkg::OUT_W-1:0]   o_mapped_y,
    output logic                                 o_clipped
);

    localparam int DL = 14;

    logic [DL:1] r_v;
    logic [DL:1] r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DL-1:1], i_valid};
        end
    end

    // clip flag of the normalizer; output saturation is or-ed in at the end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= {r_c[DL-1:1], i_clip};
        end
    end

    // coordinates carried along
    logic signed [22:0] r_xn [1:8];
    logic signed [22:0] r_yn [1:8];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn[1] <= i_xn;
            r_yn[1] <= i_yn;
            for (int s = 2; s <= 8; s++) begin
                r_xn[s] <= r_xn[s-1];
                r_yn[s] <= r_yn[s-1];
            end
        end
    end

    // stage 1: squares and cross product
    logic signed [45:0] r1_pxx, r1_pyy, r1_pxy;
    // stage 2
    logic signed [25:0] r2_x2, r2_y2, r2_xy;
    logic signed [26:0] r2_r2;
    // stage 3
    logic signed [25:0] r3_xy;
    logic signed [26:0] r3_r2;
    logic signed [27:0] r3_tx, r3_ty;
    logic signed [53:0] r3_r4p;
    logic signed [50:0] r3_k1p;
    // stage 4
    logic signed [25:0] r4_xy;
    logic signed [26:0] r4_r2;
    logic signed [27:0] r4_tx, r4_ty;
    logic signed [31:0] r4_r4;
    logic signed [29:0] r4_k1t;
    // stage 5
    logic signed [25:0] r5_xy;
    logic signed [27:0] r5_tx, r5_ty;
    logic signed [58:0] r5_r6p;
    logic signed [55:0] r5_k2p;
    logic signed [29:0] r5_k1t;
    // stage 6
    logic signed [25:0] r6_xy;
    logic signed [27:0] r6_tx, r6_ty;
    logic signed [36:0] r6_r6;
    logic signed [34:0] r6_k2t;
    logic signed [29:0] r6_k1t;
    // stage 7
    logic signed [25:0] r7_xy;
    logic signed [27:0] r7_tx, r7_ty;
    logic signed [60:0] r7_k3p;
    logic signed [36:0] r7_s12;
    // stage 8
    logic signed [25:0] r8_xy;
    logic signed [27:0] r8_tx, r8_ty;
    logic signed [40:0] r8_rad;
    // stage 9
    logic signed [63:0] r9_xr, r9_yr;
    logic signed [49:0] r9_p1xy, r9_p2xy;
    logic signed [51:0] r9_p2tx, r9_p1ty;
    // stage 10
    logic signed [43:0] r10_ax, r10_ay;
    logic signed [31:0] r10_bx, r10_by, r10_cx, r10_cy;
    // stage 11
    logic signed [38:0] r11_xd, r11_yd;
    // stage 12
    logic signed [55:0] r12_mxp, r12_myp;
    // stage 13
    logic signed [37:0] r13_mx, r13_my;
    // stage 14
    logic signed [17:0] r14_mx, r14_my;
    logic               r14_sat;

    logic signed [25:0] n_x2, n_y2;
    logic signed [44:0] n_sx, n_sy;
    logic signed [17:0] n_fx, n_fy;
    logic               n_satx, n_saty;
    logic signed [17:0] n_ox, n_oy;

    assign n_x2 = 26'(lensd_pkg::rnd_q20(64'(r1_pxx)));
    assign n_y2 = 26'(lensd_pkg::rnd_q20(64'(r1_pyy)));
    assign n_sx = 45'(r10_ax) + 45'(r10_bx) + 45'(r10_cx);
    assign n_sy = 45'(r10_ay) + 45'(r10_by) + 45'(r10_cy);
    assign n_fx = $signed({2'b00, i_cfg.fx});
    assign n_fy = $signed({2'b00, i_cfg.fy});

    always_comb begin
        n_satx = 1'b0;
        n_saty = 1'b0;
        if (r13_mx > 38'(lensd_pkg::OUT_MAX)) begin
            n_ox   = lensd_pkg::OUT_MAX;
            n_satx = 1'b1;
        end else if (r13_mx < 38'(lensd_pkg::OUT_MIN)) begin
            n_ox   = lensd_pkg::OUT_MIN;
            n_satx = 1'b1;
        end else begin
            n_ox = 18'(r13_mx);
        end
        if (r13_my > 38'(lensd_pkg::OUT_MAX)) begin
            n_oy   = lensd_pkg::OUT_MAX;
            n_saty = 1'b1;
        end else if (r13_my < 38'(lensd_pkg::OUT_MIN)) begin
            n_oy   = lensd_pkg::OUT_MIN;
            n_saty = 1'b1;
        end else begin
            n_oy = 18'(r13_my);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r1_pxx <= 46'(i_xn) * 46'(i_xn);
            r1_pyy <= 46'(i_yn) * 46'(i_yn);
            r1_pxy <= 46'(i_xn) * 46'(i_yn);
            // stage 2
            r2_x2 <= n_x2;
            r2_y2 <= n_y2;
            r2_xy <= 26'(lensd_pkg::rnd_q20(64'(r1_pxy)));
            r2_r2 <= 27'(n_x2) + 27'(n_y2);
            // stage 3
            r3_xy  <= r2_xy;
            r3_r2  <= r2_r2;
            r3_tx  <= 28'(r2_r2) + (28'(r2_x2) <<< 1);
            r3_ty  <= 28'(r2_r2) + (28'(r2_y2) <<< 1);
            r3_r4p <= 54'(r2_r2) * 54'(r2_r2);
            r3_k1p <= 51'(i_cfg.k1) * 51'(r2_r2);
            // stage 4
            r4_xy  <= r3_xy;
            r4_r2  <= r3_r2;
            r4_tx  <= r3_tx;
            r4_ty  <= r3_ty;
            r4_r4  <= 32'(lensd_pkg::rnd_q20(64'(r3_r4p)));
            r4_k1t <= 30'(lensd_pkg::rnd_q20(64'(r3_k1p)));
            // stage 5
            r5_xy  <= r4_xy;
            r5_tx  <= r4_tx;
            r5_ty  <= r4_ty;
            r5_r6p <= 59'(r4_r4) * 59'(r4_r2);
            r5_k2p <= 56'(i_cfg.k2) * 56'(r4_r4);
            r5_k1t <= r4_k1t;
            // stage 6
            r6_xy  <= r5_xy;
            r6_tx  <= r5_tx;
            r6_ty  <= r5_ty;
            r6_r6  <= 37'(lensd_pkg::rnd_q20(64'(r5_r6p)));
            r6_k2t <= 35'(lensd_pkg::rnd_q20(64'(r5_k2p)));
            r6_k1t <= r5_k1t;
            // stage 7
            r7_xy  <= r6_xy;
            r7_tx  <= r6_tx;
            r7_ty  <= r6_ty;
            r7_k3p <= 61'(i_cfg.k3) * 61'(r6_r6);
            r7_s12 <= lensd_pkg::ONE_Q20 + 37'(r6_k1t) + 37'(r6_k2t);
            // stage 8: radial gain
            r8_xy  <= r7_xy;
            r8_tx  <= r7_tx;
            r8_ty  <= r7_ty;
            r8_rad <= 41'(r7_s12) + 41'(lensd_pkg::rnd_q20(64'(r7_k3p)));
            // stage 9
            r9_xr   <= 64'(r_xn[8]) * 64'(r8_rad);
            r9_yr   <= 64'(r_yn[8]) * 64'(r8_rad);
            r9_p1xy <= 50'(i_cfg.p1) * 50'(r8_xy);
            r9_p2xy <= 50'(i_cfg.p2) * 50'(r8_xy);
            r9_p2tx <= 52'(i_cfg.p2) * 52'(r8_tx);
            r9_p1ty <= 52'(i_cfg.p1) * 52'(r8_ty);
            // stage 10
            r10_ax <= 44'(lensd_pkg::rnd_q20(r9_xr));
            r10_ay <= 44'(lensd_pkg::rnd_q20(r9_yr));
            r10_bx <= 32'(lensd_pkg::rnd_q20(64'(r9_p1xy) <<< 1));
            r10_cy <= 32'(lensd_pkg::rnd_q20(64'(r9_p2xy) <<< 1));
            r10_cx <= 32'(lensd_pkg::rnd_q20(64'(r9_p2tx)));
            r10_by <= 32'(lensd_pkg::rnd_q20(64'(r9_p1ty)));
            // stage 11: saturating here leaves the final clamp unchanged
            if (n_sx > 45'(lensd_pkg::XD_MAX)) begin
                r11_xd <= lensd_pkg::XD_MAX;
            end else if (n_sx < 45'(lensd_pkg::XD_MIN)) begin
                r11_xd <= lensd_pkg::XD_MIN;
            end else begin
                r11_xd <= 39'(n_sx);
            end
            if (n_sy > 45'(lensd_pkg::XD_MAX)) begin
                r11_yd <= lensd_pkg::XD_MAX;
            end else if (n_sy < 45'(lensd_pkg::XD_MIN)) begin
                r11_yd <= lensd_pkg::XD_MIN;
            end else begin
                r11_yd <= 39'(n_sy);
            end
            // stage 12
            r12_mxp <= 56'(n_fx) * 56'(r11_xd);
            r12_myp <= 56'(n_fy) * 56'(r11_yd);
            // stage 13
            r13_mx <= 38'(lensd_pkg::rnd_q20(64'(r12_mxp))) + $signed({22'h0, i_cfg.cx});
            r13_my <= 38'(lensd_pkg::rnd_q20(64'(r12_myp))) + $signed({22'h0, i_cfg.cy});
            // stage 14
            r14_mx  <= n_ox;
            r14_my  <= n_oy;
            r14_sat <= n_satx | n_saty;
        end
    end

    assign o_valid    = r_v[DL];
    assign o_mapped_x = r14_mx;
    assign o_mapped_y = r14_my;
    assign o_clipped  = r_c[DL] | r14_sat;

endmodule

// File: verif/lens_distortion_point_map_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lens_distortion_point_map_core_test
// Self-checking bench for the lens distortion point map. Each accepted pixel
// transaction is run through a behavioral Brown-Conrady distortion model and
// the mapped coordinate and clip flag are compared against the block output.
// ----------------------------------------------------------------------------
module lens_distortion_point_map_core_test;

    localparam int  PIPE_DRAIN  = 60;       // drain wait, a bit above the pipeline latency
    localparam int  CYCLE_LIMIT = 600000;
    localparam longint NRM_HI = 64'sd4194303;
    localparam longint NRM_LO = -64'sd4194304;
    localparam longint MAP_HI = 64'sd131071;
    localparam longint MAP_LO = -64'sd131072;

    typedef struct {
        logic signed [17:0] mx;
        logic signed [17:0] my;
        logic               clip;
    } t_mapped;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [15:0]        i_pixel_x;
    logic [15:0]        i_pixel_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [17:0] o_mapped_x;
    logic signed [17:0] o_mapped_y;
    logic               o_clipped;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;

    // shadow of the lens registers
    logic [15:0]        lens_fx, lens_fy, lens_cx, lens_cy;
    logic signed [23:0] lens_k1, lens_k2, lens_k3, lens_p1, lens_p2;

    t_mapped mapped_queue[$];
    int      err_count;
    int      points_sent;
    int      points_checked;
    int      clipped_seen;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;

    lens_distortion_point_map_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_mapped_x (o_mapped_x),
        .o_mapped_y (o_mapped_y),
        .o_clipped  (o_clipped),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint round_q20(longint v);
        return (v + 64'sd524288) >>> 20;
    endfunction

    // pixel to normalized q20, rounded to nearest with ties away from zero
    function automatic longint normalize_axis(logic [15:0] pix, logic [15:0] ctr,
                                              logic [15:0] foc, inout bit clip);
        longint d, f, mag, q;
        d   = longint'(pix) - longint'(ctr);
        f   = (foc == 16'd0) ? 64'sd1 : longint'(foc);
        mag = (d < 0 ? -d : d) <<< 20;
        q   = (mag + f / 2) / f;
        if (d < 0) q = -q;
        if (q > NRM_HI) begin
            clip = 1'b1;
            q    = NRM_HI;
        end else if (q < NRM_LO) begin
            clip = 1'b1;
            q    = NRM_LO;
        end
        return q;
    endfunction

    function automatic longint saturate_out(longint v, inout bit clip);
        if (v > MAP_HI) begin
            clip = 1'b1;
            return MAP_HI;
        end
        if (v < MAP_LO) begin
            clip = 1'b1;
            return MAP_LO;
        end
        return v;
    endfunction

    function automatic t_mapped distort_point(logic [15:0] px, logic [15:0] py);
        t_mapped r;
        bit      clip;
        longint  xn, yn, x2, y2, xy, r2, r4, r6, rad, xd, yd, fx, fy, mx, my;
        longint  k1, k2, k3, p1, p2;
        clip = 1'b0;
        k1 = lens_k1; k2 = lens_k2; k3 = lens_k3; p1 = lens_p1; p2 = lens_p2;
        fx = (lens_fx == 16'd0) ? 64'sd1 : longint'(lens_fx);
        fy = (lens_fy == 16'd0) ? 64'sd1 : longint'(lens_fy);
        xn  = normalize_axis(px, lens_cx, lens_fx, clip);
        yn  = normalize_axis(py, lens_cy, lens_fy, clip);
        x2  = round_q20(xn * xn);
        y2  = round_q20(yn * yn);
        xy  = round_q20(xn * yn);
        r2  = x2 + y2;
        r4  = round_q20(r2 * r2);
        r6  = round_q20(r4 * r2);
        rad = 64'sd1048576 + round_q20(k1 * r2) + round_q20(k2 * r4) + round_q20(k3 * r6);
        xd  = round_q20(xn * rad) + round_q20(2 * p1 * xy) + round_q20(p2 * (r2 + 2 * x2));
        yd  = round_q20(yn * rad) + round_q20(p1 * (r2 + 2 * y2)) + round_q20(2 * p2 * xy);
        mx  = saturate_out(round_q20(fx * xd) + longint'(lens_cx), clip);
        my  = saturate_out(round_q20(fy * yd) + longint'(lens_cy), clip);
        r.mx   = mx[17:0];
        r.my   = my[17:0];
        r.clip = clip;
        return r;
    endfunction

    task automatic write_reg(lensd_pkg::t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            lensd_pkg::CFG_FOCAL_X:   lens_fx = data[15:0];
            lensd_pkg::CFG_FOCAL_Y:   lens_fy = data[15:0];
            lensd_pkg::CFG_PRINCIPAL: begin
                lens_cx = data[15:0];
                lens_cy = data[31:16];
            end
            lensd_pkg::CFG_K1:        lens_k1 = data[23:0];
            lensd_pkg::CFG_K2:        lens_k2 = data[23:0];
            lensd_pkg::CFG_K3:        lens_k3 = data[23:0];
            lensd_pkg::CFG_P1:        lens_p1 = data[23:0];
            default:                  lens_p2 = data[23:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (mapped_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic load_lens(logic [15:0] fx, logic [15:0] fy, logic [31:0] pp,
                             logic [23:0] k1, logic [23:0] k2, logic [23:0] k3,
                             logic [23:0] p1, logic [23:0] p2);
        // no transaction may be offered while the registers change
        i_valid <= 1'b0;
        wait_drained();
        write_reg(lensd_pkg::CFG_FOCAL_X, {16'd0, fx});
        write_reg(lensd_pkg::CFG_FOCAL_Y, {16'd0, fy});
        write_reg(lensd_pkg::CFG_PRINCIPAL, pp);
        write_reg(lensd_pkg::CFG_K1, {8'd0, k1});
        write_reg(lensd_pkg::CFG_K2, {8'd0, k2});
        write_reg(lensd_pkg::CFG_K3, {8'd0, k3});
        write_reg(lensd_pkg::CFG_P1, {8'd0, p1});
        write_reg(lensd_pkg::CFG_P2, {8'd0, p2});
    endtask

    // valid stays up between back-to-back transactions, dropped only for a gap
    task automatic send_point(logic [15:0] px, logic [15:0] py);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (!o_ready);
        mapped_queue.insert(mapped_queue.size(), distort_point(px, py));
        points_sent++;
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coef();
        case ($urandom_range(5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'($urandom());
            default: return 24'(int'($urandom_range(8191)) - 4096) <<< $urandom_range(6);
        endcase
    endfunction

    function automatic logic [15:0] rand_focal();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(4000, 20000));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_point(16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h1234, 16'h8000);
        end_burst();
    endtask

    task automatic test_directed_extremes();
        // centered optics with mild barrel and tangential terms
        load_lens(16'd8000, 16'd9000, {16'd4800, 16'd6400},
                  24'hFF0000, 24'h004000, 24'hFFF000, 24'h000800, 24'hFFF800);
        send_point(16'd6400, 16'd4800);
        send_point(16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'hFFFF, 16'd0);
        send_point(16'hAAAA, 16'h5555);
        // zero focal behaves as one and drives normalize into its clamp
        load_lens(16'd0, 16'd0, 32'h80008000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        send_point(16'd0, 16'hFFFF);
        send_point(16'h8000, 16'h8001);
        send_point(16'h7FFF, 16'h8000);
        // big coefficients push the output into saturation
        load_lens(16'hFFFF, 16'd1, 32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF, 24'h7FFFFF);
        send_point(16'd0, 16'd0);
        send_point(16'h0100, 16'hFFFE);
        load_lens(16'hFFFF, 16'hFFFF, 32'd0, 24'h800000, 24'h800000, 24'h800000,
                  24'h800000, 24'h800000);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h8000, 16'h0001);
        send_point(16'd0, 16'd0);
        end_burst();
    endtask

    task automatic test_random_phase(int sidle, int rstall, int count);
        logic [15:0] fx, fy, px, py;
        logic [31:0] pp;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int blk = 0; blk < 3; blk++) begin
            fx = rand_focal();
            fy = rand_focal();
            pp = ($urandom_range(3) == 0) ? $urandom() :
                 {16'($urandom_range(1000, 9000)), 16'($urandom_range(1000, 12000))};
            load_lens(fx, fy, pp, rand_coef(), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef());
            for (int n = 0; n < count / 3; n++) begin
                if ($urandom_range(3) == 0) begin
                    px = 16'($urandom());
                    py = 16'($urandom());
                end else begin
                    px = 16'($urandom_range(0, 24000));
                    py = 16'($urandom_range(0, 18000));
                end
                send_point(px, py);
                if (n == count / 6 && blk == 1) begin
                    // hold off until the pipeline empties out
                    end_burst();
                    while (mapped_queue.size() != 0) @(posedge i_clk);
                end
            end
            end_burst();
        end
    endtask

    // result checker and receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_valid && i_ready) begin
                if (mapped_queue.size() == 0) begin
                    $error("unexpected transaction x=%0d y=%0d", o_mapped_x, o_mapped_y);
                    err_count++;
                end else begin
                    t_mapped e;
                    e = mapped_queue.pop_front();
                    points_checked++;
                    if (e.clip) clipped_seen++;
                    if (o_mapped_x !== e.mx) begin
                        $error("mapped_x exp %0d got %0d", e.mx, o_mapped_x);
                        err_count++;
                    end
                    if (o_mapped_y !== e.my) begin
                        $error("mapped_y exp %0d got %0d", e.my, o_mapped_y);
                        err_count++;
                    end
                    if (o_clipped !== e.clip) begin
                        $error("clipped exp %0d got %0d", e.clip, o_clipped);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = lensd_pkg::CFG_FOCAL_X;
        i_cfg_data     = '0;
        cycle_count    = 0;
        err_count      = 0;
        points_sent    = 0;
        points_checked = 0;
        clipped_seen   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lens_fx = lensd_pkg::FOCAL_RST;
        lens_fy = lensd_pkg::FOCAL_RST;
        lens_cx = '0; lens_cy = '0;
        lens_k1 = '0; lens_k2 = '0; lens_k3 = '0; lens_p1 = '0; lens_p2 = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_extremes();
        test_random_phase(0, 0, 210);
        test_random_phase(84, 0, 210);
        test_random_phase(0, 84, 210);
        test_random_phase(21, 21, 210);

        wait_drained();
        $display("covered %0d pixel transactions, %0d checked, %0d expected clipped",
                 points_sent, points_checked, clipped_seen);
        $display("over directed extremes and random lens settings under four flow mixes");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lensd_pkg.sv
rtl/lensd_norm.sv
rtl/lensd_dist.sv
rtl/lens_distortion_point_map_core.sv
verif/lens_distortion_point_map_core_test.sv
